@@ hdl/fbpa_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// fbpa_pkg: shared types and constants of the block pool allocator
// Field widths, register and status codes, request/response words and the
// controller state encoding.
// ---------------------------------------------------------------------------
package fbpa_pkg;

	localparam int MAX_BLOCKS_DEF = 256;

	// Field and register widths
	localparam int OFFSET_W  = 24;
	localparam int COUNT_W   = 9;
	localparam int SIZE_W    = 17;
	localparam int REG_IDX_W = 2;

	// Mark store geometry: one row holds the marks of sixteen blocks
	localparam int ROW_BITS  = 16;
	localparam int ROW_SHIFT = 4;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;

	// Register reset values and size limit
	localparam logic [COUNT_W-1:0] COUNT_RST = 9'd256;
	localparam logic [SIZE_W-1:0]  SIZE_RST  = 17'd64;
	localparam logic [SIZE_W-1:0]  SIZE_MAX  = 17'd65536;

	// Request kinds
	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

	typedef struct packed {
		logic                func;
		logic [OFFSET_W-1:0] release_offset;
	} fbpa_req_t;

	typedef struct packed {
		logic [1:0]          result_status;
		logic [OFFSET_W-1:0] block_offset;
	} fbpa_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HINT_CHK,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_REL_WR
	} fbpa_state_t;

endpackage : fbpa_pkg
`default_nettype wire

@@ hdl/fbpa_mark_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// fbpa_mark_ram: taken-mark store
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module fbpa_mark_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [fbpa_pkg::ROW_BITS-1:0] wdata,
	input  logic [AW-1:0]                 raddr,
	output logic [fbpa_pkg::ROW_BITS-1:0] rdata
);
	import fbpa_pkg::*;

	logic [ROW_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule : fbpa_mark_ram
`default_nettype wire

@@ hdl/fbpa_divider.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// fbpa_divider: restoring divider, one quotient bit per cycle
// Divides a byte offset by the block size; done pulses with the quotient.
// ---------------------------------------------------------------------------
module fbpa_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fbpa_pkg::OFFSET_W-1:0] dividend,
	input  logic [fbpa_pkg::SIZE_W-1:0]   divisor,
	output logic                          done,
	output logic [fbpa_pkg::OFFSET_W-1:0] quotient
);
	import fbpa_pkg::*;

	localparam int STEP_W = $clog2(OFFSET_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(OFFSET_W - 1);

	logic [SIZE_W-1:0]   rem_q;
	logic [OFFSET_W-1:0] quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                run_q;
	logic                done_q;

	logic [SIZE_W:0] trial;
	logic [SIZE_W:0] diff;
	logic            fits;

	always_comb begin
		trial = {rem_q, quo_q[OFFSET_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the dividend out at the top, the quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
			quo_q <= {quo_q[OFFSET_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule : fbpa_divider
`default_nettype wire

@@ hdl/fixed_block_pool_allocator_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// fixed_block_pool_allocator_core: fixed-size block pool allocator
// Allocates and releases equal-sized blocks of a pool, one taken mark per
// block in a row-organized mark store, with a hint below which no block is free.
// ---------------------------------------------------------------------------
// Usage: a request word is taken at a clock edge with start high and busy
// low. Each request yields exactly one response word on rsp, shown for one
// cycle with done high; the receiver must take it then, it cannot stall the
// block. busy is low in the cycle the response is shown, so the next
// request may follow at once. An allocate that hits the free hint reads the
// hint row, marks the block and then forms the offset; otherwise the
// allocator scans the mark store one row of sixteen marks per cycle. A
// release runs a one-bit-per-cycle divider over the 24-bit offset (the offset
// to index conversion), then clears the mark unless the offset lies outside
// the pool. After reset the block sweeps the mark store clean, one row per
// cycle, with busy high; configuration writes are taken during that sweep.
// Write block_count and block_size only while idle.
// ---------------------------------------------------------------------------
module fixed_block_pool_allocator_core #(
	parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request / response
	input  logic                           start,
	output logic                           busy,
	input  fbpa_pkg::fbpa_req_t            req,
	output logic                           done,
	output fbpa_pkg::fbpa_rsp_t            rsp,
	// configuration
	input  logic                           wr_en,
	input  logic [fbpa_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [fbpa_pkg::SIZE_W-1:0]    wr_data
);
	import fbpa_pkg::*;

	// Index width holds 0..MAX_BLOCKS (the hint may sit one past the last block)
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int ROWS   = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W  = (CNT_W > ROW_SHIFT) ? CNT_W : ROW_SHIFT + 1;
	localparam int PROD_W = (CNT_W + SIZE_W > OFFSET_W) ? CNT_W + SIZE_W : OFFSET_W;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	function automatic logic [ROW_W-1:0] row_of(input logic [CNT_W-1:0] i);
		logic [IDX_W-1:0] e;
		e = IDX_W'(i);
		return ROW_W'(e >> ROW_SHIFT);
	endfunction

	function automatic logic [ROW_BITS-1:0] mask_of(input logic [CNT_W-1:0] i);
		logic [IDX_W-1:0] e;
		e = IDX_W'(i);
		return ROW_BITS'(1) << e[ROW_SHIFT-1:0];
	endfunction

	// Configuration registers
	logic [COUNT_W-1:0] block_count_q;
	logic [SIZE_W-1:0]  block_size_q;

	// Controller
	fbpa_state_t state_q, state_d;
	logic [ROW_W-1:0] clr_row_q;
	logic [CNT_W-1:0] hint_q, hint_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic             ld_hint, ld_idx;

	// Scan pipeline: read row, then check it in the following cycle
	logic [ROW_W-1:0] rd_row_q;
	logic             rd_more_q;
	logic [ROW_W-1:0] chk_row_s1;
	logic             chk_vld_s1;
	logic             scan_init;

	// Mark store ports
	logic                mem_we;
	logic [ROW_W-1:0]    mem_waddr;
	logic [ROW_BITS-1:0] mem_wdata;
	logic [ROW_W-1:0]    mem_raddr;
	logic [ROW_BITS-1:0] mem_rdata;

	// Divider
	logic                div_start;
	logic                div_done;
	logic [OFFSET_W-1:0] div_quot;

	// Response
	logic             fin;
	logic             fin_mul;
	logic [1:0]       fin_status;
	fbpa_rsp_t        rsp_q;
	logic             done_q;

	// Live settings: clamp count to the pool, size into 1..65536
	logic [CNT_W-1:0]  count_live;
	logic [SIZE_W-1:0] size_live;
	logic              hint_in;
	logic [ROW_W-1:0]  scan_last;
	logic [PROD_W-1:0] prod;

	// Row check
	logic [ROW_BITS-1:0]  avail;
	logic [ROW_SHIFT-1:0] scan_bit;
	logic [CNT_W-1:0]     scan_idx;

	always_comb begin
		if (32'(block_count_q) > 32'(MAX_BLOCKS)) begin
			count_live = CNT_W'(MAX_BLOCKS);
		end else begin
			count_live = CNT_W'(block_count_q);
		end
		if (block_size_q == '0) begin
			size_live = SIZE_W'(1);
		end else if (block_size_q > SIZE_MAX) begin
			size_live = SIZE_MAX;
		end else begin
			size_live = block_size_q;
		end
		hint_in   = hint_q < count_live;
		scan_last = ROW_W'((IDX_W'(count_live) - IDX_W'(1)) >> ROW_SHIFT);
		prod      = PROD_W'(idx_q) * PROD_W'(size_live);
	end

	// Lowest free block of the checked row that lies below the count
	always_comb begin
		for (int b = 0; b < ROW_BITS; b++) begin
			avail[b] = !mem_rdata[b] &&
				(((32'(chk_row_s1) << ROW_SHIFT) | 32'(b)) < 32'(count_live));
		end
		scan_bit = '0;
		for (int b = ROW_BITS - 1; b >= 0; b--) begin
			if (avail[b]) begin
				scan_bit = ROW_SHIFT'(b);
			end
		end
		scan_idx = CNT_W'({chk_row_s1, scan_bit});
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= COUNT_RST;
			block_size_q  <= SIZE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BLOCK_COUNT: block_count_q <= wr_data[COUNT_W-1:0];
				REG_BLOCK_SIZE:  block_size_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Next state and datapath control
	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_waddr  = clr_row_q;
		mem_wdata  = '0;
		mem_raddr  = rd_row_q;
		div_start  = 1'b0;
		fin        = 1'b0;
		fin_mul    = 1'b0;
		fin_status = STATUS_OK;
		ld_idx     = 1'b0;
		idx_d      = idx_q;
		ld_hint    = 1'b0;
		hint_d     = hint_q;
		scan_init  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				// sweep every row to all-free after reset
				mem_we    = 1'b1;
				mem_waddr = clr_row_q;
				mem_wdata = '0;
				if (clr_row_q == LAST_ROW) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (req.func == FUNC_RELEASE) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end else if (hint_in) begin
						mem_raddr = row_of(hint_q);
						state_d   = ST_HINT_CHK;
					end else if (count_live == '0) begin
						fin        = 1'b1;
						fin_status = STATUS_FULL;
					end else begin
						scan_init = 1'b1;
						state_d   = ST_SCAN;
					end
				end
			end
			ST_HINT_CHK: begin
				if ((mem_rdata & mask_of(hint_q)) == '0) begin
					// hint block is free: take it, advance the hint
					mem_we    = 1'b1;
					mem_waddr = row_of(hint_q);
					mem_wdata = mem_rdata | mask_of(hint_q);
					ld_idx    = 1'b1;
					idx_d     = hint_q;
					ld_hint   = 1'b1;
					hint_d    = hint_q + CNT_W'(1);
					state_d   = ST_MUL;
				end else begin
					scan_init = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				mem_raddr = rd_row_q;
				if (chk_vld_s1) begin
					if (avail != '0) begin
						mem_we    = 1'b1;
						mem_waddr = chk_row_s1;
						mem_wdata = mem_rdata | (ROW_BITS'(1) << scan_bit);
						ld_idx    = 1'b1;
						idx_d     = scan_idx;
						ld_hint   = 1'b1;
						hint_d    = scan_idx;
						state_d   = ST_MUL;
					end else if (chk_row_s1 == scan_last) begin
						fin        = 1'b1;
						fin_status = STATUS_FULL;
						state_d    = ST_IDLE;
					end
				end
			end
			ST_MUL: begin
				fin     = 1'b1;
				fin_mul = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (div_done) begin
					if (div_quot >= OFFSET_W'(count_live)) begin
						fin        = 1'b1;
						fin_status = STATUS_OUTSIDE;
						state_d    = ST_IDLE;
					end else begin
						ld_idx    = 1'b1;
						idx_d     = CNT_W'(div_quot);
						mem_raddr = row_of(CNT_W'(div_quot));
						state_d   = ST_REL_WR;
					end
				end
			end
			ST_REL_WR: begin
				// clear the mark, lower the hint if the block sits below it
				mem_we    = 1'b1;
				mem_waddr = row_of(idx_q);
				mem_wdata = mem_rdata & ~mask_of(idx_q);
				if (idx_q < hint_q) begin
					ld_hint = 1'b1;
					hint_d  = idx_q;
				end
				fin     = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q  <= '0;
			hint_q     <= '0;
			rd_more_q  <= 1'b0;
			chk_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= fin;
			if (state_q == ST_CLEAR) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
			end
			if (ld_hint) begin
				hint_q <= hint_d;
			end
			if (scan_init) begin
				rd_more_q  <= 1'b1;
				chk_vld_s1 <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				chk_vld_s1 <= rd_more_q;
				if (rd_more_q && rd_row_q == scan_last) begin
					rd_more_q <= 1'b0;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ld_idx) begin
			idx_q <= idx_d;
		end
		if (scan_init) begin
			rd_row_q <= '0;
		end else if (state_q == ST_SCAN) begin
			chk_row_s1 <= rd_row_q;
			if (rd_more_q && rd_row_q != scan_last) begin
				rd_row_q <= rd_row_q + ROW_W'(1);
			end
		end
		if (fin) begin
			rsp_q.result_status <= fin_status;
			rsp_q.block_offset  <= fin_mul ? prod[OFFSET_W-1:0] : '0;
		end
	end

	fbpa_mark_ram #(
		.DEPTH (ROWS),
		.AW    (ROW_W)
	) u_mark_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fbpa_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.release_offset),
		.divisor  (size_live),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule : fixed_block_pool_allocator_core
`default_nettype wire
